/* rtl/arc_length_t_lookup_top_assert.svh */
// assertion macros for the arc length lookup checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef ARC_LENGTH_T_LOOKUP_TOP_ASSERT_SVH
`define ARC_LENGTH_T_LOOKUP_TOP_ASSERT_SVH

// property checked while out of reset
`define ARCLEN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that also holds across reset
`define ARCLEN_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/arclen_pkg.sv */
// shared types, codes and helpers for the arc length to t lookup
// no dependencies

package arclen_pkg;

    localparam int S_TDATA_W = 80;   // 74 bits of fields padded to bytes
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;   // 17 bit t padded to bytes
    localparam int M_TUSER_W = 2;
    localparam int CFG_W     = 9;

    localparam int T_W   = 17;
    localparam int LEN_W = 24;
    localparam int Q_W   = 25;
    localparam int CNT_W = 9;

    localparam int DIV_STEPS = 18;
    localparam int DIV_CNT_W = 5;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STAT_EMPTY  = 2'd0;
    localparam logic [1:0] STAT_BELOW  = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;
    localparam logic [1:0] STAT_INTERP = 2'd3;

    typedef enum logic [3:0] {
        IDLE,
        CHK_LAST,
        SEARCH,
        POST,
        GET_PREV,
        GET_CUR,
        MULT,
        DIVIDE,
        FINISH,
        DONE
    } state_t;

    // clamp a signed interpolation result into 0 .. 1.0
    function automatic logic [T_W-1:0] clamp_t(input logic signed [19:0] v);
        logic [T_W-1:0] r;
        if (v < 20'sd0) begin
            r = '0;
        end else if (v > 20'sd65536) begin
            r = T_ONE;
        end else begin
            r = v[T_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/arc_length_t_lookup_top.sv */
// arc length to curve parameter lookup: table memory, binary search, serial divide
// depends on arclen_pkg
//
// usage
//   s_ channel: one beat is one item; s_tuser[0] is op (0 load, 1 query),
//     s_tdata carries entry_index, entry_t, entry_length, query_length
//   m_ channel: one beat per query; m_tdata holds t_out (Q1.16, unsigned),
//     m_tuser holds status (0 empty, 1 at or below start, 2 beyond end, 3 interp)
//   cfg_ channel: writes entry_count, the number of table entries in use
// order of work
//   a load is written to the table when accepted and gives no beat
//   empty table or length at or below zero: from idle straight to DONE
//   full lookup: a read of the last entry, then k search steps, k being
//     ceil(log2(n + 1)), at most 9 for 256 entries, with one table read per
//     search step, then the reads of the pair and the 18 step restoring divider
//   s_tready is high in idle only; one query is in flight at a time
// reset and stall
//   reset clears the fsm, the output valid flag and entry_count; the table
//     itself keeps whatever it held and is valid only where written
//   a stalled result sits in the output register; loads are still taken,
//     a second query finishes and waits until the register is freed

module arc_length_t_lookup_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] entry_index, [24:8] entry_t, [48:25] entry_length,
    // [73:49] query_length, [79:74] zero
    input  logic [arclen_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] op
    input  logic [arclen_pkg::S_TUSER_W-1:0]  s_tuser,
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [16:0] t_out, [23:17] zero
    output logic [arclen_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [arclen_pkg::M_TUSER_W-1:0]  m_tuser,
    // entry_count write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arclen_pkg::CFG_W-1:0]      cfg_data
);

    import arclen_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MEM_W  = T_W + LEN_W;
    localparam int N_LIM  = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(N_LIM);

    // table memory, one word holds {t, length}
    logic [MEM_W-1:0]  mem_array [TABLE_DEPTH];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    entry_count_reg;
    logic [LEN_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    first_reg, first_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [T_W-1:0]      t0_reg, t0_next;
    logic [LEN_W-1:0]    len0_reg, len0_next;
    logic [LEN_W-1:0]    den_reg, den_next;
    logic [LEN_W-1:0]    num_reg, num_next;
    logic [T_W-1:0]      absdiff_reg, absdiff_next;
    logic                neg_reg, neg_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [DIV_STEPS-1:0] low_reg, low_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [T_W-1:0]      res_t_reg, res_t_next;
    logic [1:0]          res_st_reg, res_st_next;
    logic [T_W-1:0]      out_t_reg, out_t_next;
    logic [1:0]          out_st_reg, out_st_next;
    logic                m_valid_reg, m_valid_next;

    // input field views
    logic              in_op;
    logic [7:0]        in_index;
    logic [T_W-1:0]    in_t;
    logic [LEN_W-1:0]  in_len;
    logic [Q_W-1:0]    in_q;

    assign in_op    = s_tuser[0];
    assign in_index = s_tdata[7:0];
    assign in_t     = s_tdata[24:8];
    assign in_len   = s_tdata[48:25];
    assign in_q     = s_tdata[73:49];

    logic s_fire;
    logic out_free;
    logic [CNT_W-1:0] n_clamp;
    logic q_nonpos;

    assign s_tready  = (state_reg == IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign n_clamp   = (entry_count_reg > N_MAX) ? N_MAX : entry_count_reg;
    assign q_nonpos  = in_q[Q_W-1] || (in_q == '0);

    // memory read data views
    logic [LEN_W-1:0] rd_len;
    logic [T_W-1:0]   rd_t;

    assign rd_len = rd_data_reg[LEN_W-1:0];
    assign rd_t   = rd_data_reg[MEM_W-1:LEN_W];

    // one lower-bound search step on the word just read
    logic [CNT_W-1:0] probe;
    logic             go_right;
    logic [CNT_W-1:0] first_adv;
    logic [CNT_W-1:0] count_adv;
    logic [CNT_W-1:0] step_adv;

    assign probe     = first_reg + step_reg;
    assign go_right  = rd_len < q_reg;
    assign first_adv = go_right ? (probe + 1'b1) : first_reg;
    assign count_adv = go_right ? (count_reg - step_reg - 1'b1) : step_reg;
    assign step_adv  = count_adv >> 1;

    // segment set-up from the bracketing pair
    logic signed [LEN_W:0] den_s;
    logic                  den_pos;
    logic signed [LEN_W:0] num_s;
    logic signed [T_W:0]   diff_s;

    assign den_s   = $signed({1'b0, rd_len}) - $signed({1'b0, len0_reg});
    assign den_pos = !den_s[LEN_W] && (den_s != '0);
    assign num_s   = $signed({1'b0, q_reg}) - $signed({1'b0, len0_reg});
    assign diff_s  = $signed({1'b0, rd_t}) - $signed({1'b0, t0_reg});

    // product, quotient fits DIV_STEPS bits since num never exceeds den
    logic [LEN_W+T_W-1:0] prod;
    assign prod = num_reg * absdiff_reg;

    // restoring divide step
    logic [LEN_W:0] trial;
    logic           trial_ge;
    assign trial    = {rem_reg, low_reg[DIV_STEPS-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    logic signed [19:0] t_sum;
    assign t_sum = neg_reg ? ($signed({3'b0, t0_reg}) - $signed({2'b0, low_reg}))
                           : ($signed({3'b0, t0_reg}) + $signed({2'b0, low_reg}));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_fire && (in_op == OP_QUERY)) begin
                    if ((n_clamp == '0) || q_nonpos) begin
                        state_next = DONE;
                    end else begin
                        state_next = CHK_LAST;
                    end
                end
            end
            CHK_LAST: begin
                state_next = (q_reg >= rd_len) ? DONE : SEARCH;
            end
            SEARCH: begin
                state_next = (count_adv == '0) ? POST : SEARCH;
            end
            POST: begin
                if ((first_reg >= n_reg) || (first_reg == '0)) begin
                    state_next = DONE;
                end else begin
                    state_next = GET_PREV;
                end
            end
            GET_PREV: state_next = GET_CUR;
            GET_CUR:  state_next = den_pos ? MULT : DONE;
            MULT:     state_next = DIVIDE;
            DIVIDE: begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = FINISH;
                end
            end
            FINISH:   state_next = DONE;
            DONE: begin
                if (out_free) begin
                    state_next = IDLE;
                end
            end
            default:  state_next = IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = ADDR_W'(in_index);
        rd_en        = 1'b0;
        rd_addr      = '0;
        q_next       = q_reg;
        n_next       = n_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        t0_next      = t0_reg;
        len0_next    = len0_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        absdiff_next = absdiff_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        cnt_next     = cnt_reg;
        res_t_next   = res_t_reg;
        res_st_next  = res_st_reg;
        out_t_next   = out_t_reg;
        out_st_next  = out_st_reg;

        unique case (state_reg)
            IDLE: begin
                if (s_fire) begin
                    if (in_op == OP_LOAD) begin
                        // slots beyond the table are dropped
                        wr_en = ({24'd0, in_index} < 32'(TABLE_DEPTH));
                    end else begin
                        q_next = in_q[LEN_W-1:0];
                        n_next = n_clamp;
                        if (n_clamp == '0) begin
                            res_t_next  = '0;
                            res_st_next = STAT_EMPTY;
                        end else if (q_nonpos) begin
                            res_t_next  = '0;
                            res_st_next = STAT_BELOW;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W'(n_clamp - 1'b1);
                        end
                    end
                end
            end
            CHK_LAST: begin
                if (q_reg >= rd_len) begin
                    res_t_next  = T_ONE;
                    res_st_next = STAT_BEYOND;
                end else begin
                    first_next = '0;
                    count_next = n_reg;
                    step_next  = n_reg >> 1;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(n_reg >> 1);
                end
            end
            SEARCH: begin
                first_next = first_adv;
                count_next = count_adv;
                step_next  = step_adv;
                if (count_adv != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(first_adv + step_adv);
                end
            end
            POST: begin
                if (first_reg >= n_reg) begin
                    // only an unsorted table runs off the end
                    res_t_next  = T_ONE;
                    res_st_next = STAT_BEYOND;
                end else if (first_reg == '0) begin
                    res_t_next  = '0;
                    res_st_next = STAT_BELOW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(first_reg - 1'b1);
                end
            end
            GET_PREV: begin
                t0_next   = rd_t;
                len0_next = rd_len;
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(first_reg);
            end
            GET_CUR: begin
                if (!den_pos) begin
                    // lengths not increasing: fall back to lower t
                    res_t_next  = clamp_t($signed({3'b0, t0_reg}));
                    res_st_next = STAT_INTERP;
                end else begin
                    den_next = den_s[LEN_W-1:0];
                    if (num_s[LEN_W]) begin
                        num_next = '0;
                    end else if (num_s > den_s) begin
                        num_next = den_s[LEN_W-1:0];
                    end else begin
                        num_next = num_s[LEN_W-1:0];
                    end
                    neg_next     = diff_s[T_W];
                    absdiff_next = diff_s[T_W] ? T_W'(-diff_s) : diff_s[T_W-1:0];
                end
            end
            MULT: begin
                // upper part of the product stays below den / 2
                rem_next = {1'b0, prod[LEN_W+T_W-1:DIV_STEPS]};
                low_next = prod[DIV_STEPS-1:0];
                cnt_next = '0;
            end
            DIVIDE: begin
                rem_next = trial_ge ? LEN_W'(trial - {1'b0, den_reg}) : trial[LEN_W-1:0];
                low_next = {low_reg[DIV_STEPS-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            FINISH: begin
                res_t_next  = clamp_t(t_sum);
                res_st_next = STAT_INTERP;
            end
            DONE: begin
                if (out_free) begin
                    out_t_next  = res_t_reg;
                    out_st_next = res_st_reg;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_tready) || (state_reg == DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= IDLE;
            m_valid_reg     <= 1'b0;
            entry_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg       <= q_next;
        n_reg       <= n_next;
        first_reg   <= first_next;
        count_reg   <= count_next;
        step_reg    <= step_next;
        t0_reg      <= t0_next;
        len0_reg    <= len0_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        absdiff_reg <= absdiff_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        cnt_reg     <= cnt_next;
        res_t_reg   <= res_t_next;
        res_st_reg  <= res_st_next;
        out_t_reg   <= out_t_next;
        out_st_reg  <= out_st_next;
    end

    // table memory, one write or one read per cycle, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= {in_t, in_len};
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - T_W)'(0), out_t_reg};
    assign m_tuser  = out_st_reg;

endmodule

/* rtl/arclen_checker.sv */
// port level checks for the arc length lookup, bound to the top level
// depends on arclen_pkg and arc_length_t_lookup_top_assert.svh

`include "arc_length_t_lookup_top_assert.svh"

module arclen_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [arclen_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [arclen_pkg::M_TUSER_W-1:0]  m_tuser
);

    import arclen_pkg::*;

    // stalled beat stays put
    `ARCLEN_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
    `ARCLEN_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // t never beyond 1.0, and fixed results match their status
    `ARCLEN_ASSERT(a_t_range, m_tvalid |-> m_tdata[16:0] <= T_ONE, "t_out above 1.0")
    `ARCLEN_ASSERT(a_status_t, m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_BELOW || m_tuser == STAT_BEYOND) |-> (m_tuser == STAT_BEYOND) ? (m_tdata[16:0] == T_ONE) : (m_tdata[16:0] == '0), "t_out disagrees with status")

    // nothing comes out of reset
    `ARCLEN_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind arc_length_t_lookup_top arclen_checker u_arclen_checker (.*);

/* test/tb.sv */
// self-checking bench for arc_length_t_lookup_top: directed script, then random phases
// depends on arclen_pkg and the rtl top level; results checked against a local predictor
`timescale 1ns / 100ps

module tb;
    import arclen_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     TABLE_DEPTH   = 256;
    localparam int     IDX_W         = 8;
    localparam int     ITEM_BITS     = IDX_W + T_W + LEN_W + Q_W;
    localparam int     ITEMS_TARGET  = 2000;
    localparam int     CALM_ITEMS    = 250;   // final stretch with no idling
    localparam int     SETTLE_CYCLES = 40;    // longer than the worst lookup
    localparam int     DRAIN_LIMIT   = 5000;
    localparam longint RUN_LIMIT_NS  = 20_000_000;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic [1:0]     status;
    } lookup_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;
    typedef enum int {FILL_SORTED, FILL_OVERSHOOT, FILL_SCRAMBLED} fill_style_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CNT_W-1:0]      slot;     // entry index, or entry_count on a cfg row
        logic [T_W-1:0]        t;
        logic [LEN_W-1:0]      len;
        logic signed [Q_W-1:0] qlen;
        logic                  typed;    // expected result given in the row
        logic [T_W-1:0]        exp_t;
        logic [1:0]            exp_st;
    } script_row_t;

    localparam int SCRIPT_LEN = 26;

    // kind, slot, t, len, qlen, typed, exp_t, exp_st
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // empty table answers 0 whatever the length
        '{ROW_CFG,   0, 0, 0, 0, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 16777215, 1, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, -16777216, 1, 0, STAT_EMPTY},
        // four entries, one t above 1.0, last length at full scale
        '{ROW_LOAD,  0, 0, 0, 0, 0, 0, STAT_EMPTY},
        '{ROW_LOAD,  1, 16384, 256, 0, 0, 0, STAT_EMPTY},
        '{ROW_LOAD,  2, 131071, 1024, 0, 0, 0, STAT_EMPTY},
        '{ROW_LOAD,  3, 65536, 16777215, 0, 0, 0, STAT_EMPTY},
        '{ROW_CFG,   4, 0, 0, 0, 0, 0, STAT_EMPTY},
        // at or below zero, and at or past the end
        '{ROW_QUERY, 0, 0, 0, 0, 1, 0, STAT_BELOW},
        '{ROW_QUERY, 0, 0, 0, -1, 1, 0, STAT_BELOW},
        '{ROW_QUERY, 0, 0, 0, -16777216, 1, 0, STAT_BELOW},
        '{ROW_QUERY, 0, 0, 0, 16777215, 1, T_ONE, STAT_BEYOND},
        // interpolation, clamping of t above 1.0, falling t
        '{ROW_QUERY, 0, 0, 0, 1, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 128, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 1000, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 1024, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 1025, 0, 0, STAT_EMPTY},
        // single entry: search stops on the first entry
        '{ROW_LOAD,  0, 0, 100, 0, 0, 0, STAT_EMPTY},
        '{ROW_CFG,   1, 0, 0, 0, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 50, 1, 0, STAT_BELOW},
        '{ROW_QUERY, 0, 0, 0, 100, 1, T_ONE, STAT_BEYOND},
        // unsorted table: lengths 100, 50, 1024, full scale
        '{ROW_LOAD,  1, 40000, 50, 0, 0, 0, STAT_EMPTY},
        '{ROW_CFG,   4, 0, 0, 0, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 60, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 75, 0, 0, STAT_EMPTY},
        '{ROW_QUERY, 0, 0, 0, 16777214, 0, 0, STAT_EMPTY}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // local copy of the table and the entry count
    logic [LEN_W-1:0] len_mirror [TABLE_DEPTH];
    logic [T_W-1:0]   t_mirror   [TABLE_DEPTH];
    logic [CNT_W-1:0] count_mirror = '0;

    lookup_result_t pending_lookups [$];
    int             errors     = 0;
    int             items_sent = 0;
    int             tx_odds    = 3;    // 1 in n beats preceded by a gap, 0 for none
    int             rx_odds    = 4;    // 1 in n chance of starting a stall when none runs, 0 for none
    int             rx_hold    = 0;

    arc_length_t_lookup_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // expected t for a target length against the current table
    function automatic lookup_result_t interp_t_for_length(input logic signed [Q_W-1:0] qlen);
        lookup_result_t res;
        int             live, lo, span, half;
        longint         target, num, den, t_lo, t_hi, t_est;
        live   = (int'(count_mirror) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
        target = longint'(qlen);
        res.t  = '0;
        if (live == 0) begin
            res.status = STAT_EMPTY;
        end else if (target <= 0) begin
            res.status = STAT_BELOW;
        end else if (target >= longint'(len_mirror[live-1])) begin
            res.t      = T_ONE;
            res.status = STAT_BEYOND;
        end else begin
            // lower bound: first entry whose length is not below the target
            lo   = 0;
            span = live;
            while (span > 0) begin
                half = span / 2;
                if (longint'(len_mirror[lo+half]) < target) begin
                    lo   = lo + half + 1;
                    span = span - half - 1;
                end else begin
                    span = half;
                end
            end
            if (lo >= live) begin
                res.t      = T_ONE;
                res.status = STAT_BEYOND;
            end else if (lo == 0) begin
                res.status = STAT_BELOW;
            end else begin
                t_lo = longint'(t_mirror[lo-1]);
                t_hi = longint'(t_mirror[lo]);
                den  = longint'(len_mirror[lo]) - longint'(len_mirror[lo-1]);
                if (den <= 0) begin
                    t_est = t_lo;
                end else begin
                    num = target - longint'(len_mirror[lo-1]);
                    if (num < 0) begin
                        num = 0;
                    end
                    if (num > den) begin
                        num = den;
                    end
                    t_est = t_lo + (num * (t_hi - t_lo)) / den;   // truncates toward zero
                end
                if (t_est < 0) begin
                    t_est = 0;
                end
                if (t_est > longint'(T_ONE)) begin
                    t_est = longint'(T_ONE);
                end
                res.t      = T_W'(t_est);
                res.status = STAT_INTERP;
            end
        end
        return res;
    endfunction

    // add an expected result behind those still outstanding
    function automatic void queue_lookup(input lookup_result_t res);
        pending_lookups = {pending_lookups, res};
    endfunction

    // one input beat; valid stays high into the next call unless a gap is taken
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [T_W-1:0] t, input logic [LEN_W-1:0] len,
                             input logic signed [Q_W-1:0] qlen,
                             input logic typed, input lookup_result_t typed_res);
        if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_TUSER_W'(op);
        s_tdata  <= {{(S_TDATA_W - ITEM_BITS){1'b0}}, qlen, len, t, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_LOAD) begin
            len_mirror[idx] = len;
            t_mirror[idx]   = t;
        end else if (typed) begin
            queue_lookup(typed_res);
        end else begin
            queue_lookup(interp_t_for_length(qlen));
        end
    endtask

    // hold the sender until every lookup is answered and the block has gone quiet
    task automatic wait_results_settled();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_entry_count(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        count_mirror = value;
    endtask

    // rewrite entries 0 .. rows-1
    task automatic fill_table(input int rows, input fill_style_t style);
        longint len_acc, t_acc, t_cap;
        int     len_step, t_step, i;
        len_step = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 16777215 / rows);
        t_step   = ((style == FILL_OVERSHOOT) ? 4 : 2) * 65536 / rows + 1;
        t_cap    = (style == FILL_OVERSHOOT) ? 131071 : 65536;
        len_acc  = $urandom_range(0, len_step);
        t_acc    = $urandom_range(0, t_step);
        for (i = 0; i < rows; i++) begin
            if (style == FILL_SCRAMBLED) begin
                send_item(OP_LOAD, IDX_W'(i),
                          T_W'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 131071 : 65536)),
                          LEN_W'($urandom), Q_W'($urandom), 1'b0, '0);
            end else begin
                send_item(OP_LOAD, IDX_W'(i), T_W'(t_acc), LEN_W'(len_acc),
                          Q_W'($urandom), 1'b0, '0);
            end
            len_acc = len_acc + $urandom_range(0, len_step);
            if (len_acc > 16777215) begin
                len_acc = 16777215;
            end
            t_acc = t_acc + $urandom_range(0, t_step);
            if (t_acc > t_cap) begin
                t_acc = t_cap;
            end
        end
    endtask

    // result side back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every result beat against the oldest expectation
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result beat with no lookup outstanding: t=%0d status=%0d",
                         $time, m_tdata[T_W-1:0], m_tuser);
                errors++;
            end else begin
                want = pending_lookups.pop_front();
                if (m_tdata[T_W-1:0] !== want.t || m_tuser !== want.status) begin
                    $display("%0t: lookup mismatch: expected t=%0d status=%0d, got t=%0d status=%0d",
                             $time, want.t, want.status, m_tdata[T_W-1:0], m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        script_row_t           row;
        lookup_result_t        want;
        int                    i, k, phase, cnt, live, nq, top, pick;
        logic signed [Q_W-1:0] qv;
        fill_style_t           style;
        bit                    calm;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed script
        for (i = 0; i < SCRIPT_LEN; i++) begin
            row = SCRIPT[i];
            case (row.kind)
                ROW_CFG: begin
                    wait_results_settled();
                    write_entry_count(row.slot);
                end
                ROW_LOAD: begin
                    send_item(OP_LOAD, row.slot[IDX_W-1:0], row.t, row.len,
                              Q_W'($urandom), 1'b0, '0);
                end
                default: begin
                    want.t      = row.exp_t;
                    want.status = row.exp_st;
                    send_item(OP_QUERY, IDX_W'($urandom), T_W'($urandom), LEN_W'($urandom),
                              row.qlen, row.typed, want);
                end
            endcase
        end

        // whole table written before any count can reach past the script's entries
        fill_table(TABLE_DEPTH, FILL_SORTED);

        phase = 0;
        calm  = 1'b0;
        while (items_sent < ITEMS_TARGET) begin
            wait_results_settled();
            if (items_sent > ITEMS_TARGET - CALM_ITEMS) begin
                // one last phase runs to the end with no gaps and no stalls
                calm    = 1'b1;
                tx_odds = 0;
                rx_odds <= 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: tx_odds = 0;
                    1: tx_odds = 2;
                    2: tx_odds = 4;
                    default: tx_odds = 8;
                endcase
                case ($urandom_range(0, 3))
                    0: rx_odds <= 0;
                    1: rx_odds <= 3;
                    2: rx_odds <= 6;
                    default: rx_odds <= 12;
                endcase
            end

            // first two phases: count above the depth, then exactly the depth
            if (phase == 0) begin
                cnt = 511;
            end else if (phase == 1) begin
                cnt = TABLE_DEPTH;
            end else begin
                case ($urandom_range(0, 9))
                    0: cnt = 0;
                    1: cnt = 1;
                    2: cnt = 2;
                    3: cnt = TABLE_DEPTH;
                    4: cnt = $urandom_range(TABLE_DEPTH + 1, 511);
                    5: cnt = $urandom_range(64, TABLE_DEPTH - 1);
                    default: cnt = $urandom_range(3, 40);
                endcase
            end
            write_entry_count(CNT_W'(cnt));
            live = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

            if (phase >= 2 && live != 0 &&
                $urandom_range(0, (live > 64) ? 3 : 1) == 0) begin
                case ($urandom_range(0, 5))
                    0: style = FILL_SCRAMBLED;
                    1: style = FILL_OVERSHOOT;
                    default: style = FILL_SORTED;
                endcase
                fill_table(live, style);
            end

            nq = calm ? (ITEMS_TARGET - items_sent) : $urandom_range(10, 60);
            for (k = 0; k < nq; k++) begin
                // occasional hold mid phase until every answer is back
                if (!calm && k == nq / 2 && $urandom_range(0, 3) == 0) begin
                    wait_results_settled();
                end
                if ($urandom_range(0, 9) == 0) begin
                    // stray load, may break the ordering of the table
                    send_item(OP_LOAD, IDX_W'($urandom), T_W'($urandom_range(0, 65536)),
                              LEN_W'($urandom), Q_W'($urandom), 1'b0, '0);
                end else begin
                    top  = (live == 0) ? 0 : int'(len_mirror[live-1]);
                    pick = (live == 0) ? 0 : $urandom_range(0, live - 1);
                    case ($urandom_range(0, 15))
                        0: qv = Q_W'($urandom);
                        1: qv = Q_W'(-int'($urandom_range(1, 16777216)));
                        2: qv = '0;
                        3: qv = ($urandom_range(0, 1) == 0) ? Q_W'(16777215) : Q_W'(-16777216);
                        4: qv = Q_W'(len_mirror[pick]);
                        5: qv = Q_W'(int'(len_mirror[pick]) + (($urandom_range(0, 1) == 0) ? 1 : -1));
                        6: qv = Q_W'(top - 1 + int'($urandom_range(0, 2)));
                        default: qv = (top > 1) ? Q_W'($urandom_range(1, top))
                                                : Q_W'($urandom_range(0, 3));
                    endcase
                    send_item(OP_QUERY, IDX_W'($urandom), T_W'($urandom), LEN_W'($urandom),
                              qv, 1'b0, '0);
                end
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        for (i = 0; i < DRAIN_LIMIT && pending_lookups.size() != 0; i++) @(posedge aclk);
        if (pending_lookups.size() != 0) begin
            $display("%0t: %0d lookups never answered", $time, pending_lookups.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT_NS;
        $display("Some tests failed");
        $finish;
    end

endmodule
